// ===== hw/rtl/steering_sensor_signal_simulator_assert.svh =====
// assertion macros shared by the steering sensor simulator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef STEERING_SENSOR_SIGNAL_SIMULATOR_ASSERT_SVH
`define STEERING_SENSOR_SIGNAL_SIMULATOR_ASSERT_SVH

// condition and consequence in the same cycle
`define SSS_ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sss same-cycle check failed");

// consequence in the cycle after the condition
`define SSS_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sss next-cycle check failed");

`endif

// ===== hw/rtl/sss_pkg.sv =====
// shared types and constants of the steering sensor simulator
// no dependencies; imported by all rtl modules of the block
package sss_pkg;

  // serial arithmetic widths
  localparam int unsigned MulW    = 16;
  localparam int unsigned ProdW   = 2 * MulW;
  localparam int unsigned DivW    = 12;
  localparam int unsigned MulCntW = $clog2(MulW);
  localparam int unsigned DivCntW = $clog2(ProdW);

  // field widths
  localparam int unsigned SpeedW = 15;
  localparam int unsigned VoltW  = 13;
  localparam int unsigned VoltSW = 15;
  localparam int unsigned FreqW  = 17;
  localparam int unsigned StepW  = 25;
  localparam int unsigned OffW   = 12;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [2:0] {
    REG_SPEED_SETPOINT  = 3'd0,
    REG_SPEED_PULSES    = 3'd1,
    REG_ENGINE_PULSES   = 3'd2,
    REG_TORQUE_CENTER   = 3'd3,
    REG_TORQUE_SPAN     = 3'd4,
    REG_SWEEP_LOW       = 3'd5,
    REG_SWEEP_HIGH      = 3'd6,
    REG_SWEEP_RATE      = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    OP_STEP   = 2'd0,
    OP_SPEED  = 2'd1,
    OP_ENGINE = 2'd2,
    OP_TORQUE = 2'd3
  } op_t;

  // constant divisors and rounding biases per operation
  localparam logic [DivW-1:0]  DIV_STEP    = 12'd100;
  localparam logic [DivW-1:0]  DIV_SPEED   = 12'd3600;
  localparam logic [DivW-1:0]  DIV_ENGINE  = 12'd3;
  localparam logic [DivW-1:0]  DIV_TORQUE  = 12'd1000;
  localparam logic [ProdW-1:0] BIAS_STEP   = 32'd0;
  localparam logic [ProdW-1:0] BIAS_SPEED  = 32'd1800;
  localparam logic [ProdW-1:0] BIAS_ENGINE = 32'd1;
  localparam logic [ProdW-1:0] BIAS_TORQUE = 32'd500;

  localparam logic [SpeedW-1:0] SPEED_FLOOR = 15'd10;
  localparam logic [13:0]       RPM_FLOOR   = 14'd50;
  localparam logic [FreqW-1:0]  FREQ_MAX    = 17'h1FFFF;
  localparam logic [VoltW-1:0]  VOLT_MIN_MV = 13'd50;
  localparam logic [VoltW-1:0]  VOLT_MAX_MV = 13'd4950;

  // register reset values
  localparam logic [14:0] RST_SPEED_SETPOINT = 15'd4000;
  localparam logic [13:0] RST_SPEED_PULSES   = 14'd2548;
  localparam logic [3:0]  RST_ENGINE_PULSES  = 4'd2;
  localparam logic [12:0] RST_TORQUE_CENTER  = 13'd2500;
  localparam logic [10:0] RST_TORQUE_SPAN    = 11'd1500;
  localparam logic [14:0] RST_SWEEP_LOW      = 15'd0;
  localparam logic [14:0] RST_SWEEP_HIGH     = 15'd12000;
  localparam logic [14:0] RST_SWEEP_RATE     = 15'd200;
  localparam logic [14:0] RST_SIM_SPEED      = 15'd4000;

endpackage

// ===== hw/rtl/sss_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on sss_pkg
module sss_mul
  import sss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MulW-1:0]  mcand,
  input  logic [MulW-1:0]  mplier,
  output logic [ProdW-1:0] product,
  output unit_stat_t       stat
);

  logic [MulW-1:0]    a;
  logic [ProdW-1:0]   acc;
  logic [MulCntW-1:0] count;
  logic               busy;
  logic               done;
  logic [MulW:0]      sum;

  // add the multiplicand into the upper half when the low bit is set
  assign sum = {1'b0, acc[ProdW-1:MulW]} + (acc[0] ? {1'b0, a} : {(MulW+1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == MulCntW'(MulW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a   <= mcand;
      acc <= {{MulW{1'b0}}, mplier};
    end else if (busy) begin
      acc <= {sum, acc[MulW-1:1]};
    end
  end

  assign product   = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== hw/rtl/sss_div.sv =====
// restoring divider, one quotient bit per cycle, narrow divisor
// depends on sss_pkg
module sss_div
  import sss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ProdW-1:0] dividend,
  input  logic [DivW-1:0]  divisor,
  output logic [ProdW-1:0] quotient,
  output unit_stat_t       stat
);

  logic [DivW-1:0]    dsr;
  logic [DivW-1:0]    rem;
  logic [ProdW-1:0]   quo;
  logic [DivCntW-1:0] count;
  logic               busy;
  logic               done;
  logic [DivW:0]      trial;
  logic [DivW:0]      diff;
  logic               fits;

  // bring down the next dividend bit and try a subtract
  assign trial = {rem, quo[ProdW-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == DivCntW'(ProdW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DivW-1:0] : trial[DivW-1:0];
      quo <= {quo[ProdW-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== hw/rtl/steering_sensor_signal_simulator.sv =====
// top level of the steering sensor signal simulator
// depends on sss_pkg, sss_mul, sss_div and the assertion macro header
`include "steering_sensor_signal_simulator_assert.svh"

// Each accepted item is one tick of the simulated vehicle. The tick advances
// the speed (triangle sweep between sweep_low and sweep_high, or the fixed
// setpoint) and yields one result: two complementary torque sensor voltages
// in mV, the speed and engine pulse frequencies in 0.01 Hz, and the speed in
// 0.01 km/h. All products and quotients go through one bit-serial
// multiplier (16 shift-add steps) and one restoring divider (32 steps). A
// tick runs four such multiply/divide operations in turn (sweep step, speed
// frequency, engine frequency, torque offset). Each operation passes through
// a load state, the multiplier and then the divider. One item is worked on
// at a time; the next item is taken while the previous result still waits
// in the output register, and a result that finds the output register still
// full holds the sequencer in its last step until the waiting item is taken.
// Configuration writes take effect at once and belong only in idle periods.
module steering_sensor_signal_simulator
  import sss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // configuration write port
  input  logic                     cfg_write,
  input  logic [2:0]               cfg_index,
  input  logic [14:0]              cfg_data,
  // input items
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [15:0]              elapsed_ms,
  input  logic                     running,
  input  logic                     sweep_on,
  input  logic signed [10:0]       steer_torque,
  input  logic [13:0]              rpm_setpoint,
  // result items
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [VoltW-1:0]         torque_one_mv,
  output logic [VoltW-1:0]         torque_two_mv,
  output logic [FreqW-1:0]         speed_freq_chz,
  output logic [FreqW-1:0]         engine_freq_chz,
  output logic [SpeedW-1:0]        speed_now
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  // configuration registers
  logic [14:0] speed_setpoint;
  logic [13:0] speed_pulses_per_km;
  logic [3:0]  engine_pulses_per_rev;
  logic [12:0] torque_center_mv;
  logic [10:0] torque_span_mv;
  logic [14:0] sweep_low;
  logic [14:0] sweep_high;
  logic [14:0] sweep_rate;

  // simulation state
  logic [SpeedW-1:0] sim_speed;
  logic              sweep_rising;

  // sequencer
  state_t state;
  op_t    op;

  // captured item
  logic [15:0]        it_elapsed;
  logic               it_running;
  logic               it_sweep;
  logic signed [10:0] it_torque;
  logic [13:0]        it_rpm;

  // results waiting for the output register
  logic [VoltW-1:0] res_one;
  logic [VoltW-1:0] res_two;
  logic [FreqW-1:0] res_speed_freq;
  logic [FreqW-1:0] res_engine_freq;

  // arithmetic units
  logic             mul_start;
  logic [MulW-1:0]  mul_a;
  logic [MulW-1:0]  mul_b;
  logic [ProdW-1:0] mul_product;
  unit_stat_t       mul_stat;
  logic             div_start;
  logic [ProdW-1:0] div_dividend;
  logic [DivW-1:0]  div_divisor;
  logic [ProdW-1:0] div_quo;
  unit_stat_t       div_stat;
  logic [ProdW-1:0] bias;

  // derived operands
  logic [10:0] torque_mag;
  logic [6:0]  engine_mult;
  logic        in_accept;
  logic        op_done;
  logic        out_free;

  // sweep update terms
  logic [StepW-1:0]  step;
  logic [StepW:0]    rise_sum;
  logic              rise_hit;
  logic              fall_hit;
  logic [SpeedW-1:0] fall_val;

  // torque terms
  logic [OffW-1:0]          off;
  logic signed [VoltSW-1:0] soff;
  logic signed [VoltSW-1:0] v_one;
  logic signed [VoltSW-1:0] v_two;

  // terms of the output checks
  logic slow_shown;
  logic volt_ok;

  function automatic logic [VoltW-1:0] clamp_volt(input logic signed [VoltSW-1:0] v);
    logic [VoltW-1:0] r;
    if (v < $signed({2'b00, VOLT_MIN_MV})) begin
      r = VOLT_MIN_MV;
    end else if (v > $signed({2'b00, VOLT_MAX_MV})) begin
      r = VOLT_MAX_MV;
    end else begin
      r = v[VoltW-1:0];
    end
    return r;
  endfunction

  function automatic logic [FreqW-1:0] sat_freq(input logic [ProdW-1:0] q);
    logic [FreqW-1:0] r;
    if (q[ProdW-1:FreqW] != '0) begin
      r = FREQ_MAX;
    end else begin
      r = q[FreqW-1:0];
    end
    return r;
  endfunction

  // no item is taken while reset is held
  assign in_ready  = (state == S_IDLE) && !rst;
  assign in_accept = in_valid && in_ready;
  assign op_done   = (state == S_DIV) && div_stat.done;
  assign out_free  = !out_valid || out_ready;

  // magnitude of the torque demand; the most negative code maps to 1024
  assign torque_mag  = it_torque[10] ? 11'(-it_torque) : it_torque;
  // tach pulses times 5, the /3 comes from the divider
  assign engine_mult = {1'b0, engine_pulses_per_rev, 2'b00} + {3'b000, engine_pulses_per_rev};

  // operand selection per operation
  always_comb begin
    case (op)
      OP_STEP: begin
        mul_a       = {1'b0, sweep_rate};
        mul_b       = it_elapsed;
        div_divisor = DIV_STEP;
        bias        = BIAS_STEP;
      end
      OP_SPEED: begin
        mul_a       = {1'b0, sim_speed};
        mul_b       = {2'b00, speed_pulses_per_km};
        div_divisor = DIV_SPEED;
        bias        = BIAS_SPEED;
      end
      OP_ENGINE: begin
        mul_a       = {2'b00, it_rpm};
        mul_b       = {9'd0, engine_mult};
        div_divisor = DIV_ENGINE;
        bias        = BIAS_ENGINE;
      end
      OP_TORQUE: begin
        mul_a       = {5'd0, torque_span_mv};
        mul_b       = {5'd0, torque_mag};
        div_divisor = DIV_TORQUE;
        bias        = BIAS_TORQUE;
      end
      default: begin
        mul_a       = '0;
        mul_b       = '0;
        div_divisor = DIV_STEP;
        bias        = BIAS_STEP;
      end
    endcase
  end

  assign mul_start    = (state == S_LOAD);
  assign div_start    = (state == S_MUL) && mul_stat.done;
  // rounding bias folded in ahead of the division
  assign div_dividend = mul_product + bias;

  sss_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .product (mul_product),
    .stat    (mul_stat)
  );

  sss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // sweep step is below 2^25 for any rate and elapsed time
  assign step     = div_quo[StepW-1:0];
  assign rise_sum = {{(StepW+1-SpeedW){1'b0}}, sim_speed} + {1'b0, step};
  assign rise_hit = rise_sum >= {{(StepW+1-SpeedW){1'b0}}, sweep_high};
  // falling: speed - step <= low, kept unsigned by moving step across
  assign fall_hit = {{(StepW+1-SpeedW){1'b0}}, sim_speed}
                    <= ({{(StepW+1-SpeedW){1'b0}}, sweep_low} + {1'b0, step});
  // only used when no clamp, so step is below the speed and fits
  assign fall_val = sim_speed - step[SpeedW-1:0];

  // rounded torque offset, at most 2096 mV
  assign off   = div_quo[OffW-1:0];
  assign soff  = it_torque[10] ? -$signed({3'b000, off}) : $signed({3'b000, off});
  assign v_one = $signed({2'b00, torque_center_mv}) + soff;
  assign v_two = $signed({2'b00, torque_center_mv}) - soff;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_setpoint        <= RST_SPEED_SETPOINT;
      speed_pulses_per_km   <= RST_SPEED_PULSES;
      engine_pulses_per_rev <= RST_ENGINE_PULSES;
      torque_center_mv      <= RST_TORQUE_CENTER;
      torque_span_mv        <= RST_TORQUE_SPAN;
      sweep_low             <= RST_SWEEP_LOW;
      sweep_high            <= RST_SWEEP_HIGH;
      sweep_rate            <= RST_SWEEP_RATE;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_SPEED_SETPOINT: speed_setpoint        <= cfg_data;
        REG_SPEED_PULSES:   speed_pulses_per_km   <= cfg_data[13:0];
        REG_ENGINE_PULSES:  engine_pulses_per_rev <= cfg_data[3:0];
        REG_TORQUE_CENTER:  torque_center_mv      <= cfg_data[12:0];
        REG_TORQUE_SPAN:    torque_span_mv        <= cfg_data[10:0];
        REG_SWEEP_LOW:      sweep_low             <= cfg_data;
        REG_SWEEP_HIGH:     sweep_high            <= cfg_data;
        REG_SWEEP_RATE:     sweep_rate            <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, simulation state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op           <= OP_STEP;
      out_valid    <= 1'b0;
      sim_speed    <= RST_SIM_SPEED;
      sweep_rising <= 1'b1;
    end else begin
      // a taken item leaves unless a new result replaces it in this cycle
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            op    <= OP_STEP;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= S_MUL;
        end
        S_MUL: begin
          if (mul_stat.done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            case (op)
              OP_STEP: begin
                // the speed only moves while running
                if (it_running && it_sweep) begin
                  if (sweep_rising) begin
                    if (rise_hit) begin
                      sim_speed    <= sweep_high;
                      sweep_rising <= 1'b0;
                    end else begin
                      sim_speed <= rise_sum[SpeedW-1:0];
                    end
                  end else begin
                    if (fall_hit) begin
                      sim_speed    <= sweep_low;
                      sweep_rising <= 1'b1;
                    end else begin
                      sim_speed <= fall_val;
                    end
                  end
                end else if (it_running) begin
                  sim_speed <= speed_setpoint;
                end
                op    <= OP_SPEED;
                state <= S_LOAD;
              end
              OP_SPEED: begin
                op    <= OP_ENGINE;
                state <= S_LOAD;
              end
              OP_ENGINE: begin
                op    <= OP_TORQUE;
                state <= S_LOAD;
              end
              OP_TORQUE: begin
                state <= S_FIN;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_FIN: begin
          // hand over once the output register is free or being emptied
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      it_elapsed <= elapsed_ms;
      it_running <= running;
      it_sweep   <= sweep_on;
      it_torque  <= steer_torque;
      it_rpm     <= rpm_setpoint;
    end
  end

  // per-operation results
  always_ff @(posedge clk) begin
    if (op_done) begin
      case (op)
        OP_SPEED: begin
          // stopped or crawling gives no speed pulses
          if (it_running && (sim_speed > SPEED_FLOOR)) begin
            res_speed_freq <= sat_freq(div_quo);
          end else begin
            res_speed_freq <= '0;
          end
        end
        OP_ENGINE: begin
          if (it_running && (it_rpm > RPM_FLOOR)) begin
            res_engine_freq <= sat_freq(div_quo);
          end else begin
            res_engine_freq <= '0;
          end
        end
        OP_TORQUE: begin
          res_one <= clamp_volt(v_one);
          res_two <= clamp_volt(v_two);
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if ((state == S_FIN) && out_free) begin
      torque_one_mv   <= res_one;
      torque_two_mv   <= res_two;
      speed_freq_chz  <= res_speed_freq;
      engine_freq_chz <= res_engine_freq;
      speed_now       <= sim_speed;
    end
  end

  assign slow_shown = out_valid && (speed_now <= SPEED_FLOOR);
  assign volt_ok    = (torque_one_mv >= VOLT_MIN_MV) && (torque_one_mv <= VOLT_MAX_MV) &&
                      (torque_two_mv >= VOLT_MIN_MV) && (torque_two_mv <= VOLT_MAX_MV);

  // one item in flight at a time
  `SSS_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)
  // both arithmetic units are quiet whenever the sequencer is idle
  `SSS_ASSERT_SAME(a_units_quiet, clk, rst, state == S_IDLE, !mul_stat.busy && !div_stat.busy)
  // crawling speed never shows speed pulses
  `SSS_ASSERT_SAME(a_slow_speed, clk, rst, slow_shown, speed_freq_chz == '0)
  // both voltages stay inside the clamp window
  `SSS_ASSERT_SAME(a_volt_range, clk, rst, out_valid, volt_ok)

endmodule

// ===== tb/sss_reading_checker.sv =====
// reading checker for the steering sensor simulator: watches the register,
// tick and reading channels, predicts each reading and compares it field by field
// depends on sss_pkg for widths, register codes and output limits
module sss_reading_checker
  import sss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [2:0]             cfg_index,
  input  logic [14:0]            cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [15:0]            elapsed_ms,
  input  logic                   running,
  input  logic                   sweep_on,
  input  logic signed [10:0]     steer_torque,
  input  logic [13:0]            rpm_setpoint,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [VoltW-1:0]       torque_one_mv,
  input  logic [VoltW-1:0]       torque_two_mv,
  input  logic [FreqW-1:0]       speed_freq_chz,
  input  logic [FreqW-1:0]       engine_freq_chz,
  input  logic [SpeedW-1:0]      speed_now,
  output int                     fail_count,
  output int                     outstanding,
  output int                     readings_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0]        elapsed_ms;
    logic               running;
    logic               sweep_on;
    logic signed [10:0] steer_torque;
    logic [13:0]        rpm_setpoint;
  } tick_t;

  typedef struct packed {
    logic [VoltW-1:0]  torque_one_mv;
    logic [VoltW-1:0]  torque_two_mv;
    logic [FreqW-1:0]  speed_freq_chz;
    logic [FreqW-1:0]  engine_freq_chz;
    logic [SpeedW-1:0] speed_now;
  } reading_t;

  // register copies
  logic [14:0] set_speed;
  logic [13:0] pulses_per_km;
  logic [3:0]  pulses_per_rev;
  logic [12:0] center_mv;
  logic [10:0] span_mv;
  logic [14:0] sweep_floor;
  logic [14:0] sweep_ceiling;
  logic [14:0] sweep_step_rate;

  // vehicle state
  logic [14:0] vehicle_speed;
  logic        heading_up;

  reading_t expected_readings[$];

  // signed compare, a voltage below zero clamps to the bottom
  function automatic longint clamp_mv(longint v);
    if (v < longint'(VOLT_MIN_MV)) return longint'(VOLT_MIN_MV);
    if (v > longint'(VOLT_MAX_MV)) return longint'(VOLT_MAX_MV);
    return v;
  endfunction

  // advances the vehicle by one tick and returns the reading it yields
  function automatic reading_t advance_tick(tick_t t);
    longint   rate_l, elapsed_l, step, s, lo, hi;
    longint   fsp, fen, tq, prod, mag, offset;
    reading_t r;
    fsp = 0;
    fen = 0;
    if (t.running) begin
      if (t.sweep_on) begin
        rate_l = longint'(sweep_step_rate);
        elapsed_l = longint'(t.elapsed_ms);
        step = (rate_l * elapsed_l) / 100;
        s = longint'(vehicle_speed);
        lo = longint'(sweep_floor);
        hi = longint'(sweep_ceiling);
        if (heading_up) begin
          s = s + step;
          if (s >= hi) begin
            s = hi;
            heading_up = 1'b0;
          end
        end else begin
          s = s - step;
          if (s <= lo) begin
            s = lo;
            heading_up = 1'b1;
          end
        end
        vehicle_speed = s[14:0];
      end else begin
        vehicle_speed = set_speed;
      end
      if (vehicle_speed > SPEED_FLOOR) begin
        fsp = (longint'(vehicle_speed) * longint'(pulses_per_km) + 1800) / 3600;
        if (fsp > longint'(FREQ_MAX)) fsp = longint'(FREQ_MAX);
      end
      if (t.rpm_setpoint > RPM_FLOOR) begin
        fen = (longint'(t.rpm_setpoint) * longint'(pulses_per_rev) * 5 + 1) / 3;
        if (fen > longint'(FREQ_MAX)) fen = longint'(FREQ_MAX);
      end
    end
    tq = longint'(t.steer_torque);
    prod = longint'(span_mv) * tq;
    mag = (prod < 0) ? -prod : prod;
    offset = (mag + 500) / 1000;
    if (prod < 0) offset = -offset;
    r.torque_one_mv   = VoltW'(clamp_mv(longint'(center_mv) + offset));
    r.torque_two_mv   = VoltW'(clamp_mv(longint'(center_mv) - offset));
    r.speed_freq_chz  = fsp[FreqW-1:0];
    r.engine_freq_chz = fen[FreqW-1:0];
    r.speed_now       = vehicle_speed;
    return r;
  endfunction

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    reading_t want;
    tick_t    t;
    if (rst) begin
      set_speed       = RST_SPEED_SETPOINT;
      pulses_per_km   = RST_SPEED_PULSES;
      pulses_per_rev  = RST_ENGINE_PULSES;
      center_mv       = RST_TORQUE_CENTER;
      span_mv         = RST_TORQUE_SPAN;
      sweep_floor     = RST_SWEEP_LOW;
      sweep_ceiling   = RST_SWEEP_HIGH;
      sweep_step_rate = RST_SWEEP_RATE;
      vehicle_speed   = RST_SIM_SPEED;
      heading_up      = 1'b1;
      expected_readings.delete();
      fail_count = 0;
      readings_checked = 0;
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_SPEED_SETPOINT: set_speed       = cfg_data;
          REG_SPEED_PULSES:   pulses_per_km   = cfg_data[13:0];
          REG_ENGINE_PULSES:  pulses_per_rev  = cfg_data[3:0];
          REG_TORQUE_CENTER:  center_mv       = cfg_data[12:0];
          REG_TORQUE_SPAN:    span_mv         = cfg_data[10:0];
          REG_SWEEP_LOW:      sweep_floor     = cfg_data;
          REG_SWEEP_HIGH:     sweep_ceiling   = cfg_data;
          REG_SWEEP_RATE:     sweep_step_rate = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $error("reading arrived with no tick waiting for it");
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          check_field("torque_one_mv", longint'(want.torque_one_mv),
                      longint'(torque_one_mv));
          check_field("torque_two_mv", longint'(want.torque_two_mv),
                      longint'(torque_two_mv));
          check_field("speed_freq_chz", longint'(want.speed_freq_chz),
                      longint'(speed_freq_chz));
          check_field("engine_freq_chz", longint'(want.engine_freq_chz),
                      longint'(engine_freq_chz));
          check_field("speed_now", longint'(want.speed_now), longint'(speed_now));
          readings_checked++;
        end
      end
      if (in_valid && in_ready) begin
        t.elapsed_ms   = elapsed_ms;
        t.running      = running;
        t.sweep_on     = sweep_on;
        t.steer_torque = steer_torque;
        t.rpm_setpoint = rpm_setpoint;
        expected_readings.push_back(advance_tick(t));
      end
    end
    outstanding = expected_readings.size();
  end

endmodule

// ===== tb/steering_sensor_signal_simulator_tb.sv =====
// top of the steering sensor simulator testbench: clock, reset, register
// settings, tick stimulus, reading sink with random stalls, and the verdict
// depends on sss_pkg, the block itself and sss_reading_checker
module steering_sensor_signal_simulator_tb
  import sss_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT    = 1_500_000;
  localparam int SQUEEZE_CYCLES = 3000;
  localparam int DRAIN_TAIL     = 400;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [2:0]           cfg_index;
  logic [14:0]          cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [15:0]          elapsed_ms;
  logic                 running;
  logic                 sweep_on;
  logic signed [10:0]   steer_torque;
  logic [13:0]          rpm_setpoint;
  logic                 out_valid;
  logic                 out_ready;
  logic [VoltW-1:0]     torque_one_mv;
  logic [VoltW-1:0]     torque_two_mv;
  logic [FreqW-1:0]     speed_freq_chz;
  logic [FreqW-1:0]     engine_freq_chz;
  logic [SpeedW-1:0]    speed_now;

  int fail_count;
  int outstanding;
  int readings_checked;

  // register values for the next settings phase, indexed by register code
  logic [14:0] reg_vals [8];

  int ticks_sent;
  int settings_used;
  bit no_gaps;      // sender offers back to back when set
  bit squeeze_req;  // asks the sink for one long hold-off

  steering_sensor_signal_simulator dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .elapsed_ms      (elapsed_ms),
    .running         (running),
    .sweep_on        (sweep_on),
    .steer_torque    (steer_torque),
    .rpm_setpoint    (rpm_setpoint),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .torque_one_mv   (torque_one_mv),
    .torque_two_mv   (torque_two_mv),
    .speed_freq_chz  (speed_freq_chz),
    .engine_freq_chz (engine_freq_chz),
    .speed_now       (speed_now)
  );

  sss_reading_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .elapsed_ms       (elapsed_ms),
    .running          (running),
    .sweep_on         (sweep_on),
    .steer_torque     (steer_torque),
    .rpm_setpoint     (rpm_setpoint),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .torque_one_mv    (torque_one_mv),
    .torque_two_mv    (torque_two_mv),
    .speed_freq_chz   (speed_freq_chz),
    .engine_freq_chz  (engine_freq_chz),
    .speed_now        (speed_now),
    .fail_count       (fail_count),
    .outstanding      (outstanding),
    .readings_checked (readings_checked)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[steering_sensor_signal_simulator] ERROR");
    $finish;
  end

  // reading sink: random stall before each reading, with calm stretches
  // and one long hold-off on request so the block backs up into its input
  initial begin : reading_sink
    int hold;
    int taken;
    int mode;
    bit squeezed;
    taken = 0;
    mode = 1;
    squeezed = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        hold = SQUEEZE_CYCLES;
      end else begin
        hold = (mode == 0) ? 0 : $urandom_range(0, 14);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      // mode 0 is a stretch with no stalls
      if (taken % 64 == 0) mode = $urandom_range(0, 2);
    end
  end

  // offer one tick, holding valid and payload until it is taken
  task automatic send_tick(input int gap_ms, input bit run, input bit sweep,
                           input int torque, input int rpm);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    elapsed_ms   <= gap_ms[15:0];
    running      <= run;
    sweep_on     <= sweep;
    steer_torque <= torque[10:0];
    rpm_setpoint <= rpm[13:0];
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  // random tick, mostly running so the sweep keeps moving through its bounds
  task automatic random_tick(input int sweep_pct);
    int pick, gap_ms, torque, rpm;
    bit run, sweep;
    pick = $urandom_range(0, 99);
    if (pick < 60)      gap_ms = $urandom_range(0, 300);
    else if (pick < 80) gap_ms = $urandom_range(0, 3000);
    else if (pick < 92) gap_ms = $urandom_range(0, 65535);
    else                gap_ms = ($urandom_range(0, 1) == 0) ? 0 : 65535;
    pick = $urandom_range(0, 99);
    if (pick < 80)      torque = int'($urandom_range(0, 2000)) - 1000;
    else if (pick < 95) torque = int'($urandom_range(0, 2047)) - 1024;
    else begin
      case ($urandom_range(0, 4))
        0: torque = -1024;
        1: torque = 1023;
        2: torque = -1000;
        3: torque = 1000;
        default: torque = 0;
      endcase
    end
    pick = $urandom_range(0, 99);
    if (pick < 75)      rpm = $urandom_range(0, 9000);
    else if (pick < 85) rpm = $urandom_range(45, 55);
    else                rpm = $urandom_range(0, 16383);
    run = ($urandom_range(0, 9) != 0);
    sweep = ($urandom_range(0, 99) < sweep_pct);
    send_tick(gap_ms, run, sweep, torque, rpm);
  endtask

  // drop valid and wait until every reading has come back
  task automatic wait_for_readings();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic load_settings(input int spd, input int ppk, input int ppr, input int ctr,
                               input int span, input int lo, input int hi, input int rate);
    reg_vals[REG_SPEED_SETPOINT] = spd[14:0];
    reg_vals[REG_SPEED_PULSES]   = ppk[14:0];
    reg_vals[REG_ENGINE_PULSES]  = ppr[14:0];
    reg_vals[REG_TORQUE_CENTER]  = ctr[14:0];
    reg_vals[REG_TORQUE_SPAN]    = span[14:0];
    reg_vals[REG_SWEEP_LOW]      = lo[14:0];
    reg_vals[REG_SWEEP_HIGH]     = hi[14:0];
    reg_vals[REG_SWEEP_RATE]     = rate[14:0];
  endtask

  // one settings phase: write all registers while idle, then random ticks
  task automatic run_phase(input int count, input int sweep_pct, input bit back_to_back);
    reg_index_t idx;
    for (int i = 0; i < 8; i++) begin
      idx = reg_index_t'(i);
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= reg_vals[idx];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    settings_used++;
    no_gaps = back_to_back;
    repeat (count) random_tick(sweep_pct);
    wait_for_readings();
    no_gaps = 1'b0;
  endtask

  initial begin : stimulus
    int lo;
    ticks_sent = 0;
    settings_used = 1;
    no_gaps = 1'b0;
    squeeze_req = 1'b0;
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    elapsed_ms   <= '0;
    running      <= 1'b0;
    sweep_on     <= 1'b0;
    steer_torque <= '0;
    rpm_setpoint <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed ticks on the reset settings: speed 40 km/h, sweep 0..120 km/h
    // rising at 2 km/h per tenth second
    send_tick(100, 0, 1, 0, 3000);          // stopped: frequencies zero, speed held
    send_tick(100, 1, 1, 1000, 9000);       // full positive torque, top rpm
    send_tick(0, 1, 1, -1000, 50);          // zero elapsed, engine at its floor
    send_tick(1, 1, 1, 1, 51);              // half-mV rounding away from zero
    send_tick(65535, 1, 1, -1, 0);          // huge step clamps at the top, turns down
    send_tick(10, 1, 1, 1023, 16383);       // torque past full scale, rpm all ones
    send_tick(65535, 1, 1, -1024, 8191);    // clamps at the bottom, speed zero
    send_tick(5, 1, 1, 500, 3000);          // speed exactly at the slow floor
    send_tick(1, 1, 1, -500, 3000);         // just above the floor
    send_tick(100, 1, 0, 333, 1234);        // sweep off follows the setpoint
    send_tick(100, 0, 0, -500, 9000);       // stopped with the sweep off
    send_tick(65535, 1, 1, 1000, 2000);     // rising again up to the top
    send_tick(16'hAAAA, 1, 1, 682, 14'h2AAA);
    send_tick(16'h5555, 1, 1, -683, 14'h1555);
    send_tick(16'hFFFF, 1, 0, 0, 14'h3FFF);
    send_tick(7, 1, 1, -999, 1);
    wait_for_readings();

    // low extremes, narrow sweep
    load_settings(0, 100, 1, 500, 20, 0, 300, 50);
    run_phase(150, 70, 1'b0);

    // high extremes, with one long output hold-off to back the block up
    load_settings(25000, 10000, 8, 4500, 2000, 24000, 25000, 25000);
    squeeze_req = 1'b1;
    run_phase(150, 70, 1'b0);

    // reset values written back, sender back to back
    load_settings(4000, 2548, 2, 2500, 1500, 0, 12000, 200);
    run_phase(250, 80, 1'b1);

    // zero pulse counts, setpoint on the slow floor, sweep around it
    load_settings(10, 0, 0, 2500, 2000, 5, 11, 100);
    run_phase(100, 50, 1'b0);

    // every register bit set but the sweep floor: high speeds and rpm saturate the frequencies
    load_settings(32767, 16383, 15, 8191, 2047, 0, 32767, 32767);
    run_phase(100, 50, 1'b0);

    // lower bound above upper bound
    load_settings(1234, 5000, 4, 1000, 1000, 20000, 3000, 1000);
    run_phase(100, 70, 1'b0);

    // random settings within the usual ranges
    repeat (4) begin
      lo = $urandom_range(0, 24000);
      load_settings($urandom_range(0, 25000), $urandom_range(100, 10000),
                    $urandom_range(1, 8), $urandom_range(500, 4500),
                    $urandom_range(20, 2000), lo, $urandom_range(lo + 1, 25000),
                    $urandom_range(50, 25000));
      run_phase(150, 70, 1'b0);
    end

    // a stray reading would show up here
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("run covered %0d ticks over %0d register settings, %0d readings compared",
             ticks_sent, settings_used, readings_checked);
    $display("including sweep turnarounds, stopped ticks and a long output hold-off");
    if (fail_count == 0) begin
      $display("[steering_sensor_signal_simulator] OK");
    end else begin
      $display("[steering_sensor_signal_simulator] ERROR");
    end
    $finish;
  end

endmodule
